// File: sv/rc_charge_time_measurer_top_macros.svh
// Assertion helpers for the charge time measurer checker.
// Each expects clk and arst_n in the scope of use.
`ifndef RC_CHARGE_TIME_MEASURER_TOP_MACROS_SVH
`define RC_CHARGE_TIME_MEASURER_TOP_MACROS_SVH

// Same-cycle implication.
`define RCTM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RCTM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/rctm_pkg.sv
`default_nettype none

package rctm_pkg;

	localparam int TICK_FIELD_W   = 16;
	localparam int AVG_W          = 16;
	localparam int CNT_W          = 8;
	localparam int ACC_W          = 24;
	localparam int THR_W          = 6;
	localparam int DIV_CNT_W      = $clog2(ACC_W + 1);

	localparam int TICK_BITS_DEF  = 16;
	localparam int MAX_CYCLES_DEF = 255;

	localparam logic [CNT_W-1:0] CYC_RESET = CNT_W'(16);
	localparam logic [ACC_W-1:0] ACC_MAX   = {ACC_W{1'b1}};
	localparam logic [AVG_W-1:0] AVG_MAX   = {AVG_W{1'b1}};

	localparam logic [THR_W-1:0] THR_RISE  = THR_W'(30);
	localparam logic [THR_W-1:0] THR_FALL  = THR_W'(25);

	localparam logic OP_START   = 1'b0;
	localparam logic OP_EDGE    = 1'b1;
	localparam logic KIND_DRIVE = 1'b0;
	localparam logic KIND_DONE  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LO,
		ST_LO_WAIT,
		ST_HI,
		ST_HI_WAIT,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic             start;
		logic [ACC_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [ACC_W-1:0] quotient;
	} div_rsp_t;

	function automatic logic [AVG_W-1:0] sat_avg(input logic [ACC_W-1:0] q);
		logic [AVG_W-1:0] r;
		r = (q > ACC_W'(AVG_MAX)) ? AVG_MAX : q[AVG_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/rctm_in_if.sv
`default_nettype none

interface rctm_in_if import rctm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    operation;
	logic [TICK_FIELD_W-1:0] elapsed_ticks;

	modport source (output valid, output operation, output elapsed_ticks, input ready);
	modport sink   (input valid, input operation, input elapsed_ticks, output ready);
endinterface

`default_nettype wire

// File: sv/rctm_out_if.sv
`default_nettype none

interface rctm_out_if import rctm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             result_kind;
	logic             drive_level;
	logic [THR_W-1:0] threshold_code;
	logic             await_rising;
	logic [AVG_W-1:0] average_low_ticks;
	logic [AVG_W-1:0] average_high_ticks;

	modport source (
		output valid, output result_kind, output drive_level, output threshold_code,
		output await_rising, output average_low_ticks, output average_high_ticks,
		input ready
	);
	modport sink (
		input valid, input result_kind, input drive_level, input threshold_code,
		input await_rising, input average_low_ticks, input average_high_ticks,
		output ready
	);
endinterface

`default_nettype wire

// File: sv/rctm_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle: the dividend shifts out at the
// top while quotient bits shift in at the bottom.
module rctm_div import rctm_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [ACC_W-1:0]     dvd_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     dvs_q;

	logic [CNT_W:0]       shifted;
	logic [CNT_W:0]       diff;
	logic                 qbit;

	always_comb begin
		shifted = {rem_q, dvd_q[ACC_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		qbit    = (shifted >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= DIV_CNT_W'(ACC_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= qbit ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
			dvd_q <= {dvd_q[ACC_W-2:0], qbit};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

`default_nettype wire

// File: sv/rctm_ctrl.sv
`default_nettype none

module rctm_ctrl import rctm_pkg::*; #(
	parameter int TICK_BITS = TICK_BITS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire [CNT_W-1:0]  n_eff,
	rctm_in_if.sink          in_ch,
	rctm_out_if.source       out_ch,
	output div_req_t         div_req,
	input  div_rsp_t         div_rsp
);

	localparam int TICK_USE = (TICK_BITS < TICK_FIELD_W) ? TICK_BITS : TICK_FIELD_W;
	localparam logic [TICK_FIELD_W-1:0] TICK_MASK =
		{TICK_FIELD_W{1'b1}} >> (TICK_FIELD_W - TICK_USE);

	ctrl_state_t      state_q, state_d;
	logic             busy_q;
	logic             phase_q;
	logic [CNT_W-1:0] cl_q;
	logic [ACC_W-1:0] acc_q [2];
	logic [CNT_W-1:0] dvs_q;
	logic [AVG_W-1:0] avg_lo_q, avg_hi_q;

	logic             out_valid_q;
	logic             kind_q, level_q, rise_q;
	logic [THR_W-1:0] thr_q;
	logic [AVG_W-1:0] res_lo_q, res_hi_q;

	logic             out_free, in_fire, start_fire, edge_fire;
	logic [ACC_W:0]   sum;
	logic [ACC_W-1:0] acc_sat;
	logic [CNT_W-1:0] cl_dec;
	logic             load_drive, load_done, drive_lvl;

	always_comb begin
		out_free   = !out_valid_q || out_ch.ready;
		in_fire    = in_ch.valid && in_ch.ready;
		start_fire = in_fire && (in_ch.operation == OP_START);
		edge_fire  = in_fire && (in_ch.operation == OP_EDGE) && busy_q;
		sum        = {1'b0, acc_q[phase_q]}
			+ (ACC_W + 1)'(in_ch.elapsed_ticks & TICK_MASK);
		acc_sat    = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
		// low half ends a full cycle
		cl_dec     = (!phase_q && cl_q != '0) ? cl_q - 1'b1 : cl_q;
	end

	assign in_ch.ready = (state_q == ST_IDLE) && out_free;

	always_comb begin
		state_d          = state_q;
		load_drive       = 1'b0;
		load_done        = 1'b0;
		drive_lvl        = 1'b1;
		div_req.start    = 1'b0;
		div_req.dividend = (state_q == ST_HI) ? acc_q[1] : acc_q[0];
		div_req.divisor  = dvs_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start_fire) begin
					load_drive = 1'b1;
				end else if (edge_fire) begin
					if (cl_dec != '0) begin
						load_drive = 1'b1;
						drive_lvl  = !phase_q;
					end else begin
						state_d = ST_LO;
					end
				end
			end
			ST_LO: begin
				div_req.start = 1'b1;
				state_d       = ST_LO_WAIT;
			end
			ST_LO_WAIT: begin
				if (div_rsp.done) state_d = ST_HI;
			end
			ST_HI: begin
				div_req.start = 1'b1;
				state_d       = ST_HI_WAIT;
			end
			ST_HI_WAIT: begin
				if (div_rsp.done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					load_done = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			busy_q      <= 1'b0;
			phase_q     <= 1'b0;
			cl_q        <= '0;
			acc_q[0]    <= '0;
			acc_q[1]    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_fire) begin
				busy_q   <= 1'b1;
				phase_q  <= 1'b1;
				cl_q     <= n_eff;
				acc_q[0] <= '0;
				acc_q[1] <= '0;
			end else if (edge_fire) begin
				// first full cycle is dropped
				if (cl_q < n_eff) acc_q[phase_q] <= acc_sat;
				cl_q    <= cl_dec;
				phase_q <= !phase_q;
				if (cl_dec == '0) busy_q <= 1'b0;
			end
			if (load_drive || load_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (edge_fire && cl_dec == '0) dvs_q <= n_eff - 1'b1;
		if (state_q == ST_LO_WAIT && div_rsp.done) avg_lo_q <= sat_avg(div_rsp.quotient);
		if (state_q == ST_HI_WAIT && div_rsp.done) avg_hi_q <= sat_avg(div_rsp.quotient);
		if (load_drive) begin
			kind_q   <= KIND_DRIVE;
			level_q  <= drive_lvl;
			rise_q   <= drive_lvl;
			thr_q    <= drive_lvl ? THR_RISE : THR_FALL;
			res_lo_q <= '0;
			res_hi_q <= '0;
		end else if (load_done) begin
			kind_q   <= KIND_DONE;
			level_q  <= 1'b0;
			rise_q   <= 1'b0;
			thr_q    <= '0;
			res_lo_q <= avg_lo_q;
			res_hi_q <= avg_hi_q;
		end
	end

	assign out_ch.valid              = out_valid_q;
	assign out_ch.result_kind        = kind_q;
	assign out_ch.drive_level        = level_q;
	assign out_ch.threshold_code     = thr_q;
	assign out_ch.await_rising       = rise_q;
	assign out_ch.average_low_ticks  = res_lo_q;
	assign out_ch.average_high_ticks = res_hi_q;

endmodule

`default_nettype wire

// File: sv/rc_charge_time_measurer_top.sv
// Channel   Dir  Payload
// in_ch     in   operation, elapsed_ticks
// out_ch    out  result_kind, drive_level, threshold_code, await_rising,
//                average_low_ticks, average_high_ticks
// cfg       in   cycle_count via cfg_wr_en / cfg_wr_data
//
// A start item, or an edge item that does not end the run, puts its drive command
// into the output register, where it sits from the next edge.
// The final edge of a run launches two bit-serial divisions, low then high, on
// the one shared divider; the done result is loaded in ST_OUT after both.
// Input is held off while a division runs or while a result waits unclaimed.
// arst_n clears the run state, both accumulators and cycle_count to 16.
`default_nettype none

module rc_charge_time_measurer_top import rctm_pkg::*; #(
	parameter int TICK_BITS  = TICK_BITS_DEF,
	parameter int MAX_CYCLES = MAX_CYCLES_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             cfg_wr_en,
	input  wire [CNT_W-1:0] cfg_wr_data,
	rctm_in_if.sink         in_ch,
	rctm_out_if.source      out_ch
);

	localparam int CYC_HI_I = (MAX_CYCLES < 255) ? MAX_CYCLES : 255;
	localparam logic [CNT_W-1:0] CYC_HI = CNT_W'(CYC_HI_I);
	localparam logic [CNT_W-1:0] CYC_LO = CNT_W'(2);

	logic [CNT_W-1:0] cycle_count_q;
	logic [CNT_W-1:0] n_eff;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_count_q <= CYC_RESET;
		end else if (cfg_wr_en) begin
			cycle_count_q <= cfg_wr_data;
		end
	end

	// clamp the live count into the usable range
	always_comb begin
		if (cycle_count_q < CYC_LO) begin
			n_eff = CYC_LO;
		end else if (cycle_count_q > CYC_HI) begin
			n_eff = CYC_HI;
		end else begin
			n_eff = cycle_count_q;
		end
	end

	rctm_ctrl #(
		.TICK_BITS (TICK_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.n_eff   (n_eff),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

	rctm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

`default_nettype wire

// File: sv/rctm_checker.sv
`default_nettype none
`include "rc_charge_time_measurer_top_macros.svh"

module rctm_checker import rctm_pkg::*; (
	input wire             clk,
	input wire             arst_n,
	input wire             in_valid,
	input wire             in_ready,
	input wire             in_operation,
	input wire             out_valid,
	input wire             out_kind,
	input wire             out_level,
	input wire [THR_W-1:0] out_thr,
	input wire             out_rise,
	input wire [AVG_W-1:0] out_avg_lo,
	input wire [AVG_W-1:0] out_avg_hi
);

	`RCTM_ASSERT_NEXT(a_start_drives_high, in_valid && in_ready && in_operation == OP_START, out_valid && out_kind == KIND_DRIVE && out_rise && out_level, "start gave no rising drive")
	`RCTM_ASSERT_NOW(a_drive_thr, out_valid && out_kind == KIND_DRIVE, (out_rise && out_level && out_thr == THR_RISE) || (!out_rise && !out_level && out_thr == THR_FALL), "drive threshold mismatch")
	`RCTM_ASSERT_NOW(a_drive_no_avg, out_valid && out_kind == KIND_DRIVE, out_avg_lo == '0 && out_avg_hi == '0, "drive carries averages")
	`RCTM_ASSERT_NOW(a_done_pin_low, out_valid && out_kind == KIND_DONE, !out_level && !out_rise && out_thr == '0, "done result drives pin")

endmodule

bind rc_charge_time_measurer_top rctm_checker u_rctm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.in_operation (in_ch.operation),
	.out_valid    (out_ch.valid),
	.out_kind     (out_ch.result_kind),
	.out_level    (out_ch.drive_level),
	.out_thr      (out_ch.threshold_code),
	.out_rise     (out_ch.await_rising),
	.out_avg_lo   (out_ch.average_low_ticks),
	.out_avg_hi   (out_ch.average_high_ticks)
);

`default_nettype wire
